/* src/per_dimension_sorted_unique_set_top_defines.svh */
// Assertion macros for the checker file.
`ifndef PER_DIMENSION_SORTED_UNIQUE_SET_TOP_DEFINES_SVH
`define PER_DIMENSION_SORTED_UNIQUE_SET_TOP_DEFINES_SVH
`define PDS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* src/pdsus_pkg.sv */
// Shared types and codes of the per-dimension sorted set.
package pdsus_pkg;
   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_BAD_DIM   = 3'd3,
      ST_BAD_INDEX = 3'd4,
      ST_READ_OK   = 3'd5
   } status_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef struct packed {
      logic        op;
      logic [3:0]  dimension;
      logic [63:0] value;
      logic [7:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [8:0]  position;
      logic [8:0]  list_count;
      logic [63:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic gt;
      logic eq;
   } cmp_type;

   function automatic logic is_nan(input logic [63:0] b);
      return b[62:0] > 63'h7FF0000000000000;
   endfunction

   function automatic logic [63:0] order_key(input logic [63:0] b);
      if (b[62:0] == 63'd0) return 64'h8000000000000000;
      if (b[63]) return ~b;
      return {1'b1, b[62:0]};
   endfunction
endpackage

/* src/pdsus_if.sv */
// Valid/ready channel interfaces for requests, responses and the CSR write.
interface pdsus_req_if import pdsus_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pdsus_rsp_if import pdsus_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pdsus_csr_if ();
   logic       valid;
   logic       ready;
   logic [4:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* src/per_dimension_sorted_unique_set_top.sv */
// Top level of the per-dimension sorted set of distinct doubles.
// Requests are handled one item at a time, as set by the single-port list memory and the
// shared compare unit; an insert scans its list for the place, shifts later entries up
// and writes the new value, while a bad dimension is answered without a list access.
// Synchronous reset clears the counts and sets dims_in_use to 16; no clearing pass.
module per_dimension_sorted_unique_set_top import pdsus_pkg::*; #(
   parameter int MAX_DIMS   = 16,
   parameter int LIST_DEPTH = 256
) (
   input logic      clock,
   input logic      reset,
   pdsus_req_if.sink   req,
   pdsus_rsp_if.source rsp,
   pdsus_csr_if.sink   csr
);
   localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int LW = $clog2(LIST_DEPTH);
   localparam int CW = LW + 1;
   localparam int AW = DW + LW;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_RD, S_RDWAIT, S_SCAN, S_SWAIT, S_SCMP, S_DECIDE,
      S_SHRD, S_SHWR, S_PLACE, S_RESP
   } state_type;

   state_type   state_ff;
   logic [4:0]  dims_ff;
   logic [CW-1:0] counts_ff [MAX_DIMS];
   logic [63:0] mem [MAX_DIMS*LIST_DEPTH];
   logic [63:0] mem_q_ff;
   req_type     item_ff;
   logic [DW-1:0] dim_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] k_ff;
   logic [CW-1:0] m_ff;
   rsp_type     out_ff;
   logic        rsp_valid_ff;
   logic        mem_we;
   logic [AW-1:0] mem_addr;
   logic [63:0] mem_wd;
   cmp_type     cmp_res;
   logic        dim_bad;

   pdsus_cmp u_cmp (.clock(clock), .a(item_ff.value), .b(mem_q_ff), .res_ff(cmp_res));

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = out_ff;

   always_comb begin
      dim_bad = ({1'b0, item_ff.dimension} >= dims_ff) ||
                (32'(item_ff.dimension) >= MAX_DIMS);
      mem_we = 1'b0;
      mem_wd = item_ff.value;
      mem_addr = {dim_ff, k_ff[LW-1:0]};
      case (state_ff)
         S_RD: mem_addr = {dim_ff, LW'(item_ff.entry_index)};
         S_SHRD: mem_addr = {dim_ff, m_ff[LW-1:0] - LW'(1)};
         S_SHWR: begin
            mem_we = 1'b1;
            mem_addr = {dim_ff, m_ff[LW-1:0]};
            mem_wd = mem_q_ff;
         end
         S_PLACE: mem_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      mem_q_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dims_ff <= 5'd16;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_DIMS; i++) counts_ff[i] <= '0;
      end else begin
         if (csr.valid) dims_ff <= csr.data;
         case (state_ff)
            S_IDLE: if (req.valid) begin
               item_ff <= req.payload;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               dim_ff <= DW'(item_ff.dimension);
               cnt_ff <= counts_ff[DW'(item_ff.dimension)];
               k_ff <= '0;
               out_ff <= '{status: ST_BAD_DIM, default: '0};
               if (dim_bad) state_ff <= S_RESP;
               else if (item_ff.op == OP_READ) state_ff <= S_RD;
               else state_ff <= S_SCAN;
            end
            S_RD: begin
               out_ff.position <= 9'(item_ff.entry_index);
               out_ff.list_count <= 9'(cnt_ff);
               if (CW'(item_ff.entry_index) >= cnt_ff) begin
                  out_ff.status <= ST_BAD_INDEX;
                  state_ff <= S_RESP;
               end else state_ff <= S_RDWAIT;
            end
            S_RDWAIT: begin
               out_ff.status <= ST_READ_OK;
               out_ff.read_value <= mem_q_ff;
               state_ff <= S_RESP;
            end
            S_SCAN: state_ff <= (k_ff < cnt_ff) ? S_SWAIT : S_DECIDE;
            S_SWAIT: state_ff <= S_SCMP;
            S_SCMP: if (cmp_res.gt) begin
               k_ff <= k_ff + CW'(1);
               state_ff <= S_SCAN;
            end else state_ff <= S_DECIDE;
            S_DECIDE: begin
               out_ff.position <= 9'(k_ff);
               out_ff.list_count <= 9'(cnt_ff);
               m_ff <= cnt_ff;
               if (k_ff < cnt_ff && cmp_res.eq) begin
                  out_ff.status <= ST_DUPLICATE;
                  state_ff <= S_RESP;
               end else if (32'(cnt_ff) >= LIST_DEPTH) begin
                  out_ff.status <= ST_FULL;
                  state_ff <= S_RESP;
               end else state_ff <= (cnt_ff > k_ff) ? S_SHRD : S_PLACE;
            end
            S_SHRD: state_ff <= S_SHWR;
            S_SHWR: begin
               m_ff <= m_ff - CW'(1);
               state_ff <= (m_ff - CW'(1) > k_ff) ? S_SHRD : S_PLACE;
            end
            S_PLACE: begin
               counts_ff[dim_ff] <= cnt_ff + CW'(1);
               out_ff.status <= ST_INSERTED;
               out_ff.list_count <= 9'(cnt_ff + CW'(1));
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff) rsp_valid_ff <= 1'b1;
               else if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* src/pdsus_cmp.sv */
// Shared IEEE double compare unit with a registered result.
module pdsus_cmp import pdsus_pkg::*; (
   input  logic        clock,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output cmp_type     res_ff
);
   cmp_type res_in;
   logic    any_nan;

   always_comb begin
      any_nan   = is_nan(a) || is_nan(b);
      res_in.gt = !any_nan && (order_key(a) > order_key(b));
      res_in.eq = !any_nan && (order_key(a) == order_key(b));
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end
endmodule

/* src/pdsus_checker.sv */
// Port-level checker for the sorted set top level, bound to it.
`include "per_dimension_sorted_unique_set_top_defines.svh"
module pdsus_checker import pdsus_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    req_valid,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);
   `PDS_ASSERT_IMPL(a_busy, clock, reset, rsp_valid, !req_ready, "ready while result pending")
   `PDS_ASSERT_NEXT(a_take, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   `PDS_ASSERT_IMPL(a_code, clock, reset, rsp_valid, rsp_payload.status <= 3'd5, "bad status")
   `PDS_ASSERT_IMPL(a_rdz, clock, reset, rsp_valid && rsp_payload.status != ST_READ_OK,
                    rsp_payload.read_value == 64'd0, "read value not zero")
endmodule

bind per_dimension_sorted_unique_set_top pdsus_checker u_pdsus_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready), .req_valid(req.valid),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload));

/* verif/per_dimension_sorted_unique_set_top_test.sv */
// Randomized and directed test of the per-dimension sorted set against a scoreboard model.
`timescale 1ns / 1ps
module per_dimension_sorted_unique_set_top_test import pdsus_pkg::*; ();

   localparam int NUM_DIMS = 16;
   localparam int DEPTH = 256;
   localparam int STALL_LIMIT = 20000;

   class set_scoreboard;
      logic [63:0] lists[NUM_DIMS][DEPTH];
      int unsigned counts[NUM_DIMS];
      int unsigned dims_limit;
      rsp_type expected_rsps[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned status_seen[6];

      function void clear();
         foreach (counts[d]) counts[d] = 0;
         dims_limit = 16;
         errors = 0;
         checked = 0;
      endfunction

      function bit nan_bits(logic [63:0] b);
         return b[62:0] > 63'h7FF0000000000000;
      endfunction

      function logic [63:0] sort_key(logic [63:0] b);
         if (b[62:0] == 63'd0) return 64'h8000000000000000;
         if (b[63]) return ~b;
         return {1'b1, b[62:0]};
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int unsigned cnt, k;
         e = '0;
         e.status = ST_BAD_DIM;
         if (r.dimension < dims_limit) begin
            cnt = counts[r.dimension];
            if (r.op == OP_READ) begin
               e.position = 9'(r.entry_index);
               e.list_count = 9'(cnt);
               if (r.entry_index >= cnt) e.status = ST_BAD_INDEX;
               else begin
                  e.status = ST_READ_OK;
                  e.read_value = lists[r.dimension][r.entry_index];
               end
            end else begin
               k = 0;
               while (k < cnt && !nan_bits(r.value) && !nan_bits(lists[r.dimension][k])
                      && sort_key(r.value) > sort_key(lists[r.dimension][k])) k++;
               e.position = 9'(k);
               e.list_count = 9'(cnt);
               if (k < cnt && !nan_bits(r.value) && !nan_bits(lists[r.dimension][k])
                   && sort_key(r.value) == sort_key(lists[r.dimension][k]))
                  e.status = ST_DUPLICATE;
               else if (cnt >= DEPTH) e.status = ST_FULL;
               else begin
                  for (int m = cnt; m > k; m--)
                     lists[r.dimension][m] = lists[r.dimension][m - 1];
                  lists[r.dimension][k] = r.value;
                  counts[r.dimension] = cnt + 1;
                  e.status = ST_INSERTED;
                  e.list_count = 9'(cnt + 1);
               end
            end
         end
         expected_rsps.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         checked++;
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected response %h", $time, a);
            return;
         end
         e = expected_rsps.pop_front();
         if (e.status <= 5) status_seen[e.status]++;
         if (a.status !== e.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
         end
         if (a.position !== e.position) begin
            errors++;
            $display("%0t: position expected %0d actual %0d", $time, e.position, a.position);
         end
         if (a.list_count !== e.list_count) begin
            errors++;
            $display("%0t: list_count expected %0d actual %0d", $time, e.list_count,
                     a.list_count);
         end
         if (a.read_value !== e.read_value) begin
            errors++;
            $display("%0t: read_value expected %h actual %h", $time, e.read_value,
                     a.read_value);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   pdsus_req_if req_ch ();
   pdsus_rsp_if rsp_ch ();
   pdsus_csr_if csr_ch ();

   per_dimension_sorted_unique_set_top DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr(csr_ch.sink)
   );

   set_scoreboard board;
   int unsigned send_idle_pct;
   int unsigned sink_stall_pct;
   int unsigned idle_cycles;
   int unsigned requests_sent;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      reset = 1'b1;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) board.check_response(rsp_ch.payload);
         rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("per_dimension_sorted_unique_set_top_test: FAIL");
         $finish;
      end
   end

   task automatic send_request(req_type r);
      do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(r);
      requests_sent++;
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (board.expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_dims(logic [4:0] n);
      wait_drained();
      csr_ch.valid <= 1'b1;
      csr_ch.data <= n;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      board.dims_limit = n;
   endtask

   function automatic logic [63:0] pick_value();
      case ($urandom_range(9))
         0: return 64'h0000000000000000;
         1: return 64'h8000000000000000;
         2: return 64'h7FF8000000000000 | 64'($urandom_range(7));
         3: return {1'($urandom_range(1)), 63'h7FF0000000000000};
         4: return {$urandom, $urandom};
         5: return {1'($urandom_range(1)), 52'd0, 11'($urandom_range(7))};
         default: return {1'($urandom_range(1)), 11'h3FF + 11'($urandom_range(3)),
                          52'($urandom_range(15)) << 48};
      endcase
   endfunction

   task automatic send_insert(int d, logic [63:0] v);
      req_type r;
      r = '0;
      r.op = OP_INSERT;
      r.dimension = 4'(d);
      r.value = v;
      r.entry_index = 8'($urandom);
      send_request(r);
   endtask

   task automatic send_read(int d, int i);
      req_type r;
      r = '0;
      r.op = OP_READ;
      r.dimension = 4'(d);
      r.entry_index = 8'(i);
      r.value = {$urandom, $urandom};
      send_request(r);
   endtask

   task automatic random_phase(int n, int idle_pct, int stall_pct, int top_dim);
      send_idle_pct = idle_pct;
      sink_stall_pct = stall_pct;
      repeat (n) begin
         if ($urandom_range(2) == 0) send_read($urandom_range(top_dim), $urandom_range(255));
         else send_insert($urandom_range(top_dim), pick_value());
      end
   endtask

   initial begin
      board = new();
      board.clear();
      send_idle_pct = 0;
      sink_stall_pct = 0;
      requests_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_insert(0, 64'h3FF0000000000000);
      send_insert(0, 64'hBFF0000000000000);
      send_insert(0, 64'h0000000000000000);
      send_insert(0, 64'h8000000000000000);
      send_insert(0, 64'h7FF8000000000000);
      send_insert(0, 64'hFFFFFFFFFFFFFFFF);
      send_insert(0, 64'h7FF0000000000000);
      send_insert(0, 64'hFFF0000000000000);
      send_insert(0, 64'h3FF0000000000000);
      send_insert(15, 64'hFFFFFFFFFFFFFFFF);
      send_read(0, 0);
      send_read(0, 1);
      send_read(0, 255);
      send_read(15, 0);
      send_read(3, 0);

      // Fill dimension 1 to capacity with ascending values, then push past it.
      send_idle_pct = 0;
      sink_stall_pct = 0;
      for (int i = 0; i < DEPTH; i++) send_insert(1, 64'h4000000000000000 + i);
      send_insert(1, 64'h4000000000000005);
      send_insert(1, 64'h3000000000000000);
      send_insert(1, 64'h5000000000000000);
      send_read(1, 255);

      write_dims(5'd1);
      send_insert(1, 64'h1);
      send_read(0, 2);
      write_dims(5'd0);
      send_read(0, 0);
      write_dims(5'd31);
      random_phase(80, 0, 0, 15);
      write_dims(5'd4);
      random_phase(150, 47, 0, 5);
      wait_drained();
      random_phase(150, 0, 47, 5);
      write_dims(5'd16);
      random_phase(150, 28, 28, 15);
      random_phase(40, 0, 0, 15);

      wait_drained();
      repeat (100) @(posedge clock);
      $display("Sent %0d requests with %0d settings of dims_in_use and four idling mixes;",
               requests_sent, 6);
      $display("statuses seen: ins %0d dup %0d full %0d baddim %0d badidx %0d read %0d",
               board.status_seen[0], board.status_seen[1], board.status_seen[2],
               board.status_seen[3], board.status_seen[4], board.status_seen[5]);
      if (board.errors == 0 && board.expected_rsps.size() == 0)
         $display("per_dimension_sorted_unique_set_top_test: PASS");
      else
         $display("per_dimension_sorted_unique_set_top_test: FAIL");
      $finish;
   end
endmodule

/* files.f */
+incdir+src
src/pdsus_pkg.sv
src/pdsus_if.sv
src/pdsus_cmp.sv
src/per_dimension_sorted_unique_set_top.sv
src/pdsus_checker.sv
verif/per_dimension_sorted_unique_set_top_test.sv
